[src/sps_pkg.sv]
// Package for the substring position search block.
// Holds field widths, parameter defaults, register indexes and status codes.
// No dependencies.
`default_nettype none

package sps_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;

  localparam int POS_W     = 16;
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 2;
  localparam int BYTE_W    = 8;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_SEARCH_BACK    = 3'd3,
    CFG_BOUND_POSITION = 3'd4
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BOUND_ERR = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

endpackage

`default_nettype wire

[src/sps_if.sv]
// Valid/ready channel interfaces for the substring position search block.
// Depends on sps_pkg for field widths.
`default_nettype none

interface sps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [sps_pkg::BYTE_W-1:0]  text_byte;

  modport source (output valid, output cmd, output text_byte, input ready);
  modport sink   (input valid, input cmd, input text_byte, output ready);
endinterface

interface sps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [sps_pkg::POS_W-1:0]     position;
  logic [sps_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output found, output position, output status, input ready);
  modport sink   (input valid, input found, input position, input status, output ready);
endinterface

`default_nettype wire

[src/substring_position_search.sv]
// Substring position search top level: window compare, match tracking, result register.
// Depends on sps_pkg and the channel interfaces in sps_if.sv.
//
//   channel    dir  payload                         transfer when
//   text_i     in   cmd, text_byte                  valid && ready
//   result_o   out  found, position, status         valid && ready
//   cfg        in   cfg_we_i, cfg_idx_i, cfg_data_i cfg_we_i high
//
// One item per cycle. A text byte is compared against the pattern in the cycle it
// transfers (one parallel compare over the window); end of text loads the result
// register and clears the stream state in the same edge, so the answer appears in the
// cycle after the end-of-text transfer. Input is stalled only while a result waits
// and the sink is not ready. Reset clears all state but the result payload registers.
`default_nettype none

module substring_position_search #(
  parameter int MAX_PATTERN = sps_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = sps_pkg::MAX_TEXT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sps_pkg::CFG_W-1:0]     cfg_data_i,
  sps_in_if.sink                             text_i,
  sps_out_if.source                          result_o
);

  localparam int CNT_W  = $clog2(MAX_TEXT + 1);
  localparam int POS_W  = sps_pkg::POS_W;
  localparam int LEN_W  = sps_pkg::LEN_W;
  localparam int BYTE_W = sps_pkg::BYTE_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // configuration registers
  logic [sps_pkg::CFG_W-1:0] pat_low_q, pat_high_q;
  logic [LEN_W-1:0]          pat_len_q;
  logic                      backward_q;
  logic [POS_W-1:0]          bound_q;

  // stream state
  logic [BYTE_W-1:0] win_q [MAX_PATTERN];
  logic [CNT_W-1:0]  count_q;
  logic              match_valid_q;
  logic [POS_W-1:0]  match_start_q;
  logic              overflow_q;

  // result register
  logic                         out_valid_q;
  logic                         found_q;
  logic [POS_W-1:0]             position_q;
  logic [sps_pkg::STATUS_W-1:0] status_q;

  logic                         in_xfer;
  logic                         byte_xfer;
  logic                         end_xfer;
  logic [2*sps_pkg::CFG_W-1:0]  pattern;
  logic [LEN_W-1:0]             len_eff;
  logic [BYTE_W-1:0]            win_new [MAX_PATTERN];
  logic [MAX_PATTERN:1]         hit_len;
  logic                         hit;
  logic                         at_limit;
  logic [CNT_W-1:0]             count_new;
  logic [CNT_W-1:0]             match_begin;
  logic                         take_match;
  logic                         res_found;
  logic [POS_W-1:0]             res_pos;
  sps_pkg::status_e             res_status;

  assign text_i.ready = !out_valid_q || result_o.ready;
  assign in_xfer      = text_i.valid && text_i.ready;
  assign byte_xfer    = in_xfer && (text_i.cmd == sps_pkg::CMD_TEXT);
  assign end_xfer     = in_xfer && (text_i.cmd == sps_pkg::CMD_END);

  assign pattern = {pat_high_q, pat_low_q};
  assign len_eff = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;

  assign at_limit    = (count_q == CNT_W'(MAX_TEXT));
  assign count_new   = count_q + CNT_W'(1);
  assign match_begin = count_new - CNT_W'(len_eff);

  // window as it stands once the incoming byte is shifted in, entry 0 newest
  always_comb begin
    win_new[0] = text_i.text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  // compare the window against every usable pattern length in parallel
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      hit_len[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (pattern[BYTE_W*j +: BYTE_W] != win_new[l-1-j]) begin
          hit_len[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (len_eff == LEN_W'(l)) begin
        hit = hit_len[l];
      end
    end
    if (count_new < CNT_W'(len_eff)) begin
      hit = 1'b0;
    end
  end

  // backward keeps the last match ending <= bound; forward the first starting >= bound
  always_comb begin
    take_match = 1'b0;
    if (hit) begin
      if (backward_q) begin
        take_match = CMP_W'(count_q) <= CMP_W'(bound_q);
      end else begin
        take_match = !match_valid_q && (CMP_W'(match_begin) >= CMP_W'(bound_q));
      end
    end
  end

  // answer for an end-of-text transfer
  always_comb begin
    res_found  = 1'b0;
    res_pos    = '0;
    res_status = sps_pkg::STATUS_OK;
    if (overflow_q) begin
      res_status = sps_pkg::STATUS_TOO_LONG;
    end else if (backward_q) begin
      if (count_q == '0) begin
        res_found = (len_eff == '0);
      end else if (CMP_W'(bound_q) >= CMP_W'(count_q)) begin
        res_status = sps_pkg::STATUS_BOUND_ERR;
      end else if (len_eff == '0) begin
        res_found = 1'b1;
        res_pos   = bound_q;
      end else if (match_valid_q) begin
        res_found = 1'b1;
        res_pos   = match_start_q;
      end
    end else begin
      if (len_eff == '0) begin
        res_found = 1'b1;
        res_pos   = bound_q;
      end else if (match_valid_q) begin
        res_found = 1'b1;
        res_pos   = match_start_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      backward_q <= 1'b0;
      bound_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sps_pkg::CFG_PATTERN_LOW:    pat_low_q  <= cfg_data_i;
        sps_pkg::CFG_PATTERN_HIGH:   pat_high_q <= cfg_data_i;
        sps_pkg::CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[LEN_W-1:0];
        sps_pkg::CFG_SEARCH_BACK:    backward_q <= cfg_data_i[0];
        sps_pkg::CFG_BOUND_POSITION: bound_q    <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= '0;
      end
      count_q       <= '0;
      match_valid_q <= 1'b0;
      match_start_q <= '0;
      overflow_q    <= 1'b0;
    end else if (end_xfer) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= '0;
      end
      count_q       <= '0;
      match_valid_q <= 1'b0;
      match_start_q <= '0;
      overflow_q    <= 1'b0;
    end else if (byte_xfer && !overflow_q) begin
      if (at_limit) begin
        // stop searching once the text outgrows the position range
        overflow_q <= 1'b1;
      end else begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          win_q[k] <= win_new[k];
        end
        count_q <= count_new;
        if (take_match) begin
          match_valid_q <= 1'b1;
          match_start_q <= POS_W'(match_begin);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_xfer) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_xfer) begin
      found_q    <= res_found;
      position_q <= res_pos;
      status_q   <= res_status;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.found    = found_q;
  assign result_o.position = position_q;
  assign result_o.status   = status_q;

endmodule

`default_nettype wire

[dv/substring_position_search_tb.sv]
// Self-checking testbench for substring_position_search: streams texts through the
// valid/ready text channel, predicts each answer and checks it on the result channel.
// Depends on sps_pkg, the channel interfaces in sps_if.sv and the RTL top level.
`timescale 1ns / 100ps

module substring_position_search_tb;

  typedef struct {
    logic                         cmd;
    logic [sps_pkg::BYTE_W-1:0]   text_byte;
  } text_item_t;

  typedef struct packed {
    logic                       found;
    logic [sps_pkg::POS_W-1:0]  position;
    sps_pkg::status_e           status;
  } answer_t;

  typedef logic [7:0] byte_q_t[$];

  localparam int SINK_HOLD_CYCLES = 120;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [sps_pkg::CFG_W-1:0]      cfg_data;

  sps_in_if  text_if ();
  sps_out_if res_if ();

  substring_position_search u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .text_i     (text_if),
    .result_o   (res_if)
  );

  // Predictor copy of the registers and the stream state
  logic [63:0]  pat_lo_r;
  logic [63:0]  pat_hi_r;
  logic [4:0]   pat_len_r;
  logic         back_r;
  logic [15:0]  bound_r;
  logic [7:0]   win_q [16];
  int unsigned  seen_len;
  bit           have_hit;
  logic [15:0]  hit_at;
  bit           too_long;

  text_item_t   pending_q[$];
  answer_t      answer_q[$];
  text_item_t   cur_item;
  answer_t      want;
  bit           busy_item;
  bit           in_fire;
  bit           calm_tail;
  int           src_gap;
  int           sink_gap;
  int           sink_hold;
  int           stall_req;
  int           stall_ack;
  int           fail_count;
  int           rand_items;
  int           n_texts;
  int           n_bytes;
  int           n_found;
  int           n_bound_err;
  int           n_too_long;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned live_len();
    return (pat_len_r > sps_pkg::MAX_PATTERN_DEF) ? sps_pkg::MAX_PATTERN_DEF : pat_len_r;
  endfunction

  function automatic logic [7:0] pat_byte(input int j);
    return (j < 8) ? pat_lo_r[8*j +: 8] : pat_hi_r[8*(j-8) +: 8];
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    int unsigned n;
    int unsigned start_at;
    int unsigned end_at;
    int          i;
    bit          same;
    if (too_long) return;
    if (seen_len >= sps_pkg::MAX_TEXT_DEF) begin
      too_long = 1'b1;
      return;
    end
    for (i = 15; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = b;
    seen_len++;
    n = live_len();
    if (n == 0 || seen_len < n) return;
    same = 1'b1;
    for (i = 0; i < n; i++) begin
      if (pat_byte(i) != win_q[n-1-i]) same = 1'b0;
    end
    if (!same) return;
    start_at = seen_len - n;
    end_at   = seen_len - 1;
    if (back_r) begin
      if (end_at <= bound_r) begin
        have_hit = 1'b1;
        hit_at   = start_at[15:0];
      end
    end else if (!have_hit && start_at >= bound_r) begin
      have_hit = 1'b1;
      hit_at   = start_at[15:0];
    end
  endfunction

  function automatic answer_t close_text();
    answer_t      a;
    int unsigned  n;
    int           i;
    a.found    = 1'b0;
    a.position = '0;
    a.status   = sps_pkg::STATUS_OK;
    n = live_len();
    if (too_long) begin
      a.status = sps_pkg::STATUS_TOO_LONG;
    end else if (back_r) begin
      if (seen_len == 0) begin
        a.found = (n == 0);
      end else if (bound_r >= seen_len) begin
        a.status = sps_pkg::STATUS_BOUND_ERR;
      end else if (n == 0) begin
        a.found    = 1'b1;
        a.position = bound_r;
      end else if (have_hit) begin
        a.found    = 1'b1;
        a.position = hit_at;
      end
    end else if (n == 0) begin
      a.found    = 1'b1;
      a.position = bound_r;
    end else if (have_hit) begin
      a.found    = 1'b1;
      a.position = hit_at;
    end
    // Stream state returns to zero for the next text; registers stay
    for (i = 0; i < 16; i++) win_q[i] = 8'h00;
    seen_len = 0;
    have_hit = 1'b0;
    hit_at   = '0;
    too_long = 1'b0;
    return a;
  endfunction

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    int      i;
    for (i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    return q;
  endfunction

  function automatic logic [127:0] pack_pat(input string s);
    logic [127:0] p;
    int           i;
    p = '0;
    for (i = 0; i < s.len() && i < 16; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  task automatic write_reg(input sps_pkg::cfg_idx_e idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      sps_pkg::CFG_PATTERN_LOW:    pat_lo_r = data;
      sps_pkg::CFG_PATTERN_HIGH:   pat_hi_r = data;
      sps_pkg::CFG_PATTERN_LENGTH: pat_len_r = data[4:0];
      sps_pkg::CFG_SEARCH_BACK:    back_r = data[0];
      sps_pkg::CFG_BOUND_POSITION: bound_r = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_search(input logic [127:0] pat, input logic [4:0] plen,
                            input logic back, input logic [15:0] bound);
    write_reg(sps_pkg::CFG_PATTERN_LOW, pat[63:0]);
    write_reg(sps_pkg::CFG_PATTERN_HIGH, pat[127:64]);
    write_reg(sps_pkg::CFG_PATTERN_LENGTH, 64'(plen));
    write_reg(sps_pkg::CFG_SEARCH_BACK, 64'(back));
    write_reg(sps_pkg::CFG_BOUND_POSITION, 64'(bound));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_text(input byte_q_t t);
    text_item_t it;
    int         i;
    for (i = 0; i < t.size(); i++) begin
      it.cmd       = sps_pkg::CMD_TEXT;
      it.text_byte = t[i];
      pending_q.insert(pending_q.size(), it);
    end
    it.cmd       = sps_pkg::CMD_END;
    it.text_byte = 8'($urandom);
    pending_q.insert(pending_q.size(), it);
  endtask

  // Hold until every queued transfer is taken and every answer is back
  task automatic drain();
    while (pending_q.size() != 0 || busy_item || answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One configuration, then a few texts of pattern copies, alphabet and random bytes
  task automatic random_phase();
    logic [127:0] pat;
    logic [7:0]   alpha [2];
    logic [4:0]   plen;
    logic         back;
    logic [15:0]  bound;
    byte_q_t      t;
    int           plen_eff;
    int           tlen;
    int           sel;
    int           k;
    int           i;
    pat      = {$urandom, $urandom, $urandom, $urandom};
    alpha[0] = 8'($urandom);
    alpha[1] = 8'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      for (i = 0; i < 16; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 1)];
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) plen = 5'd0;
    else if (sel <= 6) plen = 5'($urandom_range(1, 4));
    else if (sel <= 8) plen = 5'($urandom_range(5, 16));
    else plen = $urandom_range(0, 1) ? 5'd31 : 5'($urandom_range(17, 30));
    plen_eff = (plen > 16) ? 16 : plen;
    back = 1'($urandom_range(0, 1));
    sel  = $urandom_range(0, 9);
    if (sel == 0) bound = 16'hFFFF;
    else if (sel == 1) bound = 16'($urandom);
    else bound = 16'($urandom_range(0, 24));
    set_search(pat, plen, back, bound);
    repeat ($urandom_range(1, 6)) begin
      t    = {};
      tlen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
      while (t.size() < tlen) begin
        k = $urandom_range(0, 5);
        if (plen_eff > 0 && k <= 1) begin
          for (i = 0; i < plen_eff; i++) t.insert(t.size(), pat[8*i +: 8]);
        end else if (k == 2) begin
          t.insert(t.size(), 8'($urandom));
        end else begin
          t.insert(t.size(), alpha[$urandom_range(0, 1)]);
        end
      end
      rand_items += t.size() + 1;
      queue_text(t);
    end
    drain();
  endtask

  // Sender: one item held until its transfer, random gaps between items
  always @(negedge clk) begin
    if (in_fire) busy_item = 1'b0;
    if (src_gap > 0) begin
      src_gap--;
    end else if (!busy_item && !calm_tail && rst_n && $urandom_range(0, 6) == 0) begin
      src_gap = $urandom_range(1, 13);
    end
    if (!busy_item && src_gap == 0 && pending_q.size() > 0) begin
      cur_item  = pending_q.pop_front();
      busy_item = 1'b1;
    end
    text_if.valid     <= busy_item;
    text_if.cmd       <= cur_item.cmd;
    text_if.text_byte <= cur_item.text_byte;
  end

  // Receiver: random ready gaps plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_ack != stall_req) begin
      stall_ack = stall_req;
      sink_hold = SINK_HOLD_CYCLES;
    end
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (sink_gap > 0) begin
      sink_gap--;
    end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 13);
    end
    res_if.ready <= (sink_hold == 0 && sink_gap == 0);
  end

  always @(posedge clk) begin
    in_fire = rst_n && text_if.valid && text_if.ready;
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with no answer pending: found=%0d position=%0d status=%0d",
                 $time, res_if.found, res_if.position, res_if.status);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (want.found) n_found++;
        if (want.status == sps_pkg::STATUS_BOUND_ERR) n_bound_err++;
        if (want.status == sps_pkg::STATUS_TOO_LONG) n_too_long++;
        if (res_if.found !== want.found) begin
          $display("%0t: found mismatch, expected %0d, got %0d",
                   $time, want.found, res_if.found);
          fail_count++;
        end
        if (res_if.position !== want.position) begin
          $display("%0t: position mismatch, expected %0d, got %0d",
                   $time, want.position, res_if.position);
          fail_count++;
        end
        if (res_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, res_if.status);
          fail_count++;
        end
      end
    end
    if (in_fire) begin
      if (text_if.cmd == sps_pkg::CMD_END) begin
        answer_q.insert(answer_q.size(), close_text());
        n_texts++;
      end else begin
        scan_byte(text_if.text_byte);
        n_bytes++;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("%0t: timeout, %0d answers still pending", $time, answer_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    text_if.valid     = 1'b0;
    text_if.cmd       = sps_pkg::CMD_TEXT;
    text_if.text_byte = '0;
    res_if.ready      = 1'b0;
    cur_item.cmd       = sps_pkg::CMD_TEXT;
    cur_item.text_byte = '0;
    pat_lo_r  = '0;
    pat_hi_r  = '0;
    pat_len_r = '0;
    back_r    = 1'b0;
    bound_r   = '0;
    for (int i = 0; i < 16; i++) win_q[i] = 8'h00;
    seen_len = 0;
    have_hit = 1'b0;
    hit_at   = '0;
    too_long = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: empty pattern, forward, bound 0, on an empty text
    queue_text(to_bytes(""));
    drain();
    // Forward: first start at or after the bound
    set_search(pack_pat("ab"), 5'd2, 1'b0, 16'd3);
    queue_text(to_bytes("ababab"));
    drain();
    // Backward: last end at or before the bound, empty text, bound past the end
    set_search(pack_pat("ab"), 5'd2, 1'b1, 16'd4);
    queue_text(to_bytes("ababab"));
    queue_text(to_bytes(""));
    queue_text(to_bytes("ab"));
    drain();
    // Backward with an empty pattern: valid bound and empty text
    set_search(pack_pat(""), 5'd0, 1'b1, 16'd1);
    queue_text(to_bytes("abc"));
    queue_text(to_bytes(""));
    drain();
    // Forward with an empty pattern returns the bound even past the text
    set_search(pack_pat(""), 5'd0, 1'b0, 16'hFFFF);
    queue_text(to_bytes("a"));
    drain();

    // Long sink hold-off with several texts queued so the input backs up
    stall_req++;
    queue_text(to_bytes("abab"));
    queue_text(to_bytes("ba"));
    queue_text(to_bytes("ab"));
    queue_text(to_bytes(""));
    drain();

    while (rand_items < 300) random_phase();
    stall_req++;
    while (rand_items < 600) random_phase();
    calm_tail = 1'b1;
    while (rand_items < 750) random_phase();

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d texts with %0d text bytes in both directions, with long sink stalls.",
             n_texts, n_bytes);
    $display("Answers: %0d found, %0d bound errors, %0d overlong texts, %0d mismatches.",
             n_found, n_bound_err, n_too_long, fail_count);
    if (answer_q.size() != 0) $display("%0d answers never arrived", answer_q.size());
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
